/* rtl/core/ipm_pkg.sv */
// Shared widths and pipeline depths for the invariant mass block.
package ipm_pkg;

    localparam int FIELD_W   = 20;
    localparam int IN_W      = 8 * FIELD_W;
    localparam int OUT_W     = 22;
    localparam int OUT_TW    = 24;
    localparam int RAD_W     = 46;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQ_W      = 40;
    localparam int DOT_W     = 43;
    localparam int MSUM_W    = 41;
    localparam int PROD_W    = 2 * ROOT_W;
    localparam int RADS_W    = 50;
    // squares, sums, root, product, radicand, root, output register
    localparam int LAT       = 1 + 1 + ROOT_W + 1 + 1 + ROOT_W + 1;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

endpackage

/* rtl/core/ipm_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
module ipm_isqrt
    import ipm_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  x_reg [ROOT_W];
    logic [REM_W-1:0]  r_reg [ROOT_W];
    logic [ROOT_W-1:0] q_reg [ROOT_W];
    logic [RAD_W-1:0]  x_next [ROOT_W];
    logic [REM_W-1:0]  r_next [ROOT_W];
    logic [ROOT_W-1:0] q_next [ROOT_W];
    logic [RAD_W-1:0]  x_in [ROOT_W];
    logic [REM_W-1:0]  r_in [ROOT_W];
    logic [ROOT_W-1:0] q_in [ROOT_W];
    logic [REM_W+1:0]  rr [ROOT_W];
    logic [REM_W+1:0]  trial [ROOT_W];

    always_comb
    begin
        for (int s = 0; s < ROOT_W; s++)
        begin
            if (s == 0)
            begin
                x_in[s] = rad;
                r_in[s] = '0;
                q_in[s] = '0;
            end
            else
            begin
                x_in[s] = x_reg[s-1];
                r_in[s] = r_reg[s-1];
                q_in[s] = q_reg[s-1];
            end
            // bring down the next two radicand bits, try root*4+1
            rr[s]    = {r_in[s], x_in[s][RAD_W-1 -: 2]};
            trial[s] = {1'b0, q_in[s], 2'b01};
            x_next[s] = {x_in[s][RAD_W-3:0], 2'b00};
            if (rr[s] >= trial[s])
            begin
                r_next[s] = REM_W'(rr[s] - trial[s]);
                q_next[s] = {q_in[s][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                r_next[s] = rr[s][REM_W-1:0];
                q_next[s] = {q_in[s][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < ROOT_W; s++)
            begin
                x_reg[s] <= x_next[s];
                r_reg[s] <= r_next[s];
                q_reg[s] <= q_next[s];
            end
        end
    end

    assign root = q_reg[ROOT_W-1];

endmodule

/* rtl/core/two_particle_invariant_mass.sv */
// Two-body invariant mass: fully pipelined, one pair per cycle.
// Path from input beat to output beat: two 23-stage square roots in series,
// one bit per stage, plus squares, sums, product, radicand and output register.
// Throughput: one beat per cycle; a stall on the output freezes the whole pipeline.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
module two_particle_invariant_mass
    import ipm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // mass_one, mass_two, mom_one_x, mom_one_y, mom_one_z, mom_two_x, mom_two_y, mom_two_z
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // inv_mass, two zero pad bits
    output logic [OUT_TW-1:0] m_axis_tdata
);

    logic [LAT-1:0] vld_reg;
    logic           en;

    logic        [FIELD_W-1:0] m1, m2;
    logic signed [FIELD_W-1:0] ax, ay, az, bx, by, bz;

    logic        [SQ_W-1:0] m1sq_reg, m2sq_reg;
    logic        [SQ_W-1:0] ax2_reg, ay2_reg, az2_reg, bx2_reg, by2_reg, bz2_reg;
    logic signed [SQ_W-1:0] dx_reg, dy_reg, dz_reg;

    logic        [RAD_W-1:0]  e1rad_reg, e2rad_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic        [MSUM_W-1:0] msum_reg;

    logic signed [DOT_W-1:0]  dot_pipe [ROOT_W];
    logic        [MSUM_W-1:0] msum_pipe [ROOT_W];

    logic [ROOT_W-1:0] e1, e2;
    logic        [PROD_W-1:0] prod_reg;
    logic signed [DOT_W-1:0]  dot2_reg;
    logic        [MSUM_W-1:0] msum2_reg;

    logic signed [RADS_W-1:0] rad_s;
    logic        [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] mass;
    logic [OUT_W-1:0]  out_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    assign m1 = s_axis_tdata[0*FIELD_W +: FIELD_W];
    assign m2 = s_axis_tdata[1*FIELD_W +: FIELD_W];
    assign ax = s_axis_tdata[2*FIELD_W +: FIELD_W];
    assign ay = s_axis_tdata[3*FIELD_W +: FIELD_W];
    assign az = s_axis_tdata[4*FIELD_W +: FIELD_W];
    assign bx = s_axis_tdata[5*FIELD_W +: FIELD_W];
    assign by = s_axis_tdata[6*FIELD_W +: FIELD_W];
    assign bz = s_axis_tdata[7*FIELD_W +: FIELD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // squares and momentum products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1sq_reg <= SQ_W'(m1 * m1);
            m2sq_reg <= SQ_W'(m2 * m2);
            ax2_reg  <= SQ_W'(ax * ax);
            ay2_reg  <= SQ_W'(ay * ay);
            az2_reg  <= SQ_W'(az * az);
            bx2_reg  <= SQ_W'(bx * bx);
            by2_reg  <= SQ_W'(by * by);
            bz2_reg  <= SQ_W'(bz * bz);
            dx_reg   <= SQ_W'(ax * bx);
            dy_reg   <= SQ_W'(ay * by);
            dz_reg   <= SQ_W'(az * bz);
        end
    end

    // energy radicands, dot product, mass-square sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1rad_reg <= RAD_W'(m1sq_reg) + RAD_W'(ax2_reg) + RAD_W'(ay2_reg) + RAD_W'(az2_reg);
            e2rad_reg <= RAD_W'(m2sq_reg) + RAD_W'(bx2_reg) + RAD_W'(by2_reg) + RAD_W'(bz2_reg);
            dot_reg   <= DOT_W'(dx_reg) + DOT_W'(dy_reg) + DOT_W'(dz_reg);
            msum_reg  <= MSUM_W'(m1sq_reg) + MSUM_W'(m2sq_reg);
        end
    end

    ipm_isqrt u_sqrt_e1
    (
        .clk  (clk),
        .en   (en),
        .rad  (e1rad_reg),
        .root (e1)
    );

    ipm_isqrt u_sqrt_e2
    (
        .clk  (clk),
        .en   (en),
        .rad  (e2rad_reg),
        .root (e2)
    );

    // carry dot product and mass sum alongside the energy roots
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_pipe[0]  <= dot_reg;
            msum_pipe[0] <= msum_reg;
            for (int i = 1; i < ROOT_W; i++)
            begin
                dot_pipe[i]  <= dot_pipe[i-1];
                msum_pipe[i] <= msum_pipe[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= e1 * e2;
            dot2_reg  <= dot_pipe[ROOT_W-1];
            msum2_reg <= msum_pipe[ROOT_W-1];
        end
    end

    assign rad_s = RADS_W'(msum2_reg)
                 + ((RADS_W'(prod_reg) - RADS_W'(dot2_reg)) <<< 1);

    // clamp a negative radicand to zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= rad_s[RADS_W-1] ? '0 : rad_s[RAD_W-1:0];
        end
    end

    ipm_isqrt u_sqrt_mass
    (
        .clk  (clk),
        .en   (en),
        .rad  (rad_reg),
        .root (mass)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= mass[ROOT_W-1] ? OUT_MAX : mass[OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = {{(OUT_TW-OUT_W){1'b0}}, out_reg};

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output register");

endmodule

/* tb/tb_top.sv */
// Testbench for the two-particle invariant mass block: directed and random pairs.
`timescale 1ns / 1ps

module tb_top;
    import ipm_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_TW-1:0] m_axis_tdata;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1700;

    logic [IN_W-1:0]   pending_pairs[$];
    logic [OUT_W-1:0]  expected_mass[$];
    int                sender_idle_pct;
    int                receiver_stall_pct;
    int                error_count;
    int                pairs_sent;
    int                masses_seen;
    int                quiet_cycles;

    two_particle_invariant_mass u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > x)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (x >= root + probe)
            begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Predict the invariant mass of one packed pair.
    function automatic logic [OUT_W-1:0] pair_mass(logic [IN_W-1:0] beat);
        longint m1, m2, ax, ay, az, bx, by, bz;
        longint m1sq, m2sq, e1, e2, dot, rad;
        longint unsigned root;
        m1 = longint'(beat[0*FIELD_W +: FIELD_W]);
        m2 = longint'(beat[1*FIELD_W +: FIELD_W]);
        ax = longint'($signed(beat[2*FIELD_W +: FIELD_W]));
        ay = longint'($signed(beat[3*FIELD_W +: FIELD_W]));
        az = longint'($signed(beat[4*FIELD_W +: FIELD_W]));
        bx = longint'($signed(beat[5*FIELD_W +: FIELD_W]));
        by = longint'($signed(beat[6*FIELD_W +: FIELD_W]));
        bz = longint'($signed(beat[7*FIELD_W +: FIELD_W]));
        m1sq = m1 * m1;
        m2sq = m2 * m2;
        e1   = longint'(floor_root(m1sq + ax * ax + ay * ay + az * az));
        e2   = longint'(floor_root(m2sq + bx * bx + by * by + bz * bz));
        dot  = ax * bx + ay * by + az * bz;
        rad  = m1sq + m2sq + 2 * (e1 * e2 - dot);
        if (rad < 0)
            rad = 0;
        root = floor_root(rad);
        if (root > OUT_MAX)
            root = OUT_MAX;
        return root[OUT_W-1:0];
    endfunction

    function automatic logic [IN_W-1:0] pack_pair(int m1, int m2, int ax, int ay, int az,
                                                  int bx, int by, int bz);
        logic [FIELD_W-1:0] f[8];
        f = '{m1[FIELD_W-1:0], m2[FIELD_W-1:0], ax[FIELD_W-1:0], ay[FIELD_W-1:0],
              az[FIELD_W-1:0], bx[FIELD_W-1:0], by[FIELD_W-1:0], bz[FIELD_W-1:0]};
        return {f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    function automatic int rand_field();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            return 0;
        if (kind == 1)
            return ($urandom_range(0, 1) != 0) ? 524287 : -524288;
        if (kind < 4)
            return $urandom_range(0, 2000) - 1000;
        return int'($urandom);
    endfunction

    // Driver: hold data until accepted, then advance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                expected_mass.push_back(pair_mass(s_axis_tdata));
                pairs_sent++;
            end
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_pairs.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: compare each mass beat with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            quiet_cycles  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                masses_seen++;
                if (expected_mass.size() == 0)
                begin
                    $display("%0t: unexpected mass beat, actual %0d", $time,
                             m_axis_tdata[OUT_W-1:0]);
                    error_count++;
                end
                else
                begin
                    logic [OUT_W-1:0] want;
                    want = expected_mass.pop_front();
                    if (m_axis_tdata[OUT_W-1:0] !== want)
                    begin
                        $display("%0t: inv_mass mismatch, expected %0d actual %0d", $time,
                                 want, m_axis_tdata[OUT_W-1:0]);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d masses outstanding", $time,
                     expected_mass.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic run_phase(int idle_pct, int stall_pct, int n_pairs);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n_pairs)
        begin
            if ($urandom_range(0, 3) == 0)
                pending_pairs.push_back({$urandom, $urandom, $urandom, $urandom, $urandom});
            else
                pending_pairs.push_back(pack_pair(rand_field(), rand_field(), rand_field(),
                                                  rand_field(), rand_field(), rand_field(),
                                                  rand_field(), rand_field()));
        end
        wait (pending_pairs.size() == 0);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;

        // all zero, extremes, collinear photons that round below zero, mixed pairs, bit patterns
        pending_pairs.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back({IN_W{1'b1}});
        pending_pairs.push_back(pack_pair(1048575, 1048575, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(pack_pair(1048575, 1048575, 524287, 524287, 524287,
                                          -524288, -524288, -524288));
        pending_pairs.push_back(pack_pair(1048575, 1048575, -524288, -524288, -524288,
                                          -524288, -524288, -524288));
        pending_pairs.push_back(pack_pair(0, 0, 524287, 524287, 524287,
                                          524287, 524287, 524287));
        pending_pairs.push_back(pack_pair(0, 0, 3, 5, 7, 3, 5, 7));
        pending_pairs.push_back(pack_pair(0, 0, 1, 1, 1, 2, 2, 3));
        pending_pairs.push_back(pack_pair(0, 0, 1, 1, 0, 1, 1, 0));
        pending_pairs.push_back(pack_pair(0, 0, 2, 3, 0, 3, 4, 1));
        pending_pairs.push_back(pack_pair(1, 1, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(pack_pair(0, 1048575, -524288, 0, 0, 524287, 0, 0));
        pending_pairs.push_back(pack_pair(1048575, 0, 0, -1, 0, 0, 1, 0));
        pending_pairs.push_back(pack_pair(938272, 139570, 1000, -2000, 3000, -400, 500, -600));
        pending_pairs.push_back({8{20'hAAAAA}});
        pending_pairs.push_back({8{20'h55555}});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_pairs.size() == 0);

        run_phase(0, 0, N_RANDOM / 4);
        run_phase(66, 0, N_RANDOM / 4);
        run_phase(0, 66, N_RANDOM / 4);
        run_phase(9, 9, N_RANDOM / 4);

        wait (!s_axis_tvalid && expected_mass.size() == 0);
        repeat (2 * LAT + 10) @(posedge clk);

        $display("Sent %0d particle pairs (directed extremes, random and raw bit patterns)",
                 pairs_sent);
        $display("under four idle/stall mixes; %0d masses checked", masses_seen);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ipm_pkg.sv
rtl/core/ipm_isqrt.sv
rtl/core/two_particle_invariant_mass.sv
tb/tb_top.sv
